// ===== rtl/ptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
// Holds payload structs, operation/status codes and the microcode word layout.
// No dependencies.
`default_nettype none

package ptw_pkg;

	// Table geometry and address slicing
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = 9;
	localparam int VA_W              = 48;
	localparam int PA_W              = 52;
	localparam int PN_W              = 40;
	localparam int FLAG_W            = 12;

	// Entry flag bits and flag patterns
	localparam int BIT_PRESENT = 0;
	localparam int BIT_HUGE    = 7;
	localparam logic [FLAG_W-1:0] LINK_FLAGS   = 12'h007;
	localparam logic [FLAG_W-1:0] LEAF_PRESENT = 12'h001;
	localparam logic [FLAG_W-1:0] LEAF_HUGE    = 12'h080;

	typedef enum logic [1:0] {
		OP_TRANSLATE,
		OP_MAP_4K,
		OP_MAP_2M,
		OP_UNMAP_4K
	} op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_MISALIGNED,
		ST_NOT_MAPPED,
		ST_NO_FRAMES,
		ST_BAD_WALK
	} status_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [VA_W-1:0]   virt_addr;
		logic [PA_W-1:0]   phys_addr;
		logic [FLAG_W-1:0] page_flags;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [PA_W-1:0] phys_result;
		logic            flush_valid;
	} rsp_t;

	// Outcome of evaluating one table entry
	typedef enum logic [3:0] {
		DEC_GO,
		DEC_DESCEND,
		DEC_ALLOC,
		DEC_LEAF,
		DEC_WLEAF,
		DEC_UNMAP,
		DEC_NM,
		DEC_BAD,
		DEC_NOFR,
		DEC_MIS
	} dec_t;

	// Microcode fields
	typedef enum logic [1:0] {
		ACT_LATCH,
		ACT_APPLY,
		ACT_EVAL,
		ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		SEQ_WAIT_IN,
		SEQ_BR_TERM,
		SEQ_JUMP,
		SEQ_WAIT_OUT
	} seq_t;

	typedef logic [1:0] upc_t;

	localparam upc_t UPC_IDLE  = 2'd0;
	localparam upc_t UPC_APPLY = 2'd1;
	localparam upc_t UPC_EVAL  = 2'd2;
	localparam upc_t UPC_EMIT  = 2'd3;

	typedef struct packed {
		act_t act;
		seq_t seq;
		upc_t target;
	} uword_t;

	// Datapath conditions seen by the sequencer
	typedef struct packed {
		logic start;
		logic out_free;
		logic term;
	} seq_flags_t;

endpackage

`default_nettype wire

// ===== rtl/four_level_page_table_walker_core.sv =====
// Top level of the four-level page table walker.
// Ties together ptw_seq, ptw_dpath and ptw_store; depends on ptw_pkg.
//
//   Port group   Dir  Handshake            Payload
//   in_*         in   in_valid/in_ready    ptw_pkg::req_t
//   out_*        out  out_valid/out_ready  ptw_pkg::rsp_t
//   cfg_*        in   cfg_we               table_base in cfg_wdata
//
// After a transaction is accepted, apply and evaluate steps alternate, one pair
// per entry read (0 to 4), before a last apply step sets the status and the emit
// step loads the result register; the next transaction can then be accepted.
// Each level is one apply step (write/read issue) and one evaluate step on
// the registered read data of the single-read-port frame store.
// After reset the store is swept to zero; no transaction is accepted until
// the sweep ends.
// A result waits in the output register while out_ready is low; the next
// transaction may be accepted meanwhile, and its emit step holds until free.
`default_nettype none

module four_level_page_table_walker_core #(
	parameter int TABLE_FRAMES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ptw_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ptw_pkg::rsp_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic [51:0]   cfg_wdata
);
	import ptw_pkg::*;

	localparam int FW = $clog2(TABLE_FRAMES);
	localparam int AW = FW + IDX_W;

	act_t          act;
	seq_flags_t    flags;
	logic          mem_busy;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [63:0]   rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0]   wr_data;

	// Step through the control program
	ptw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.act    (act)
	);

	// Walk, allocate and report
	ptw_dpath #(
		.FRAMES (TABLE_FRAMES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.act       (act),
		.flags     (flags),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_busy  (mem_busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Hold the table frames
	ptw_store #(
		.FRAMES (TABLE_FRAMES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

endmodule

`default_nettype wire

// ===== rtl/ptw_store.sv =====
// Page-table frame store: one write port, one registered read port.
// Runs a clearing pass after reset. Depends on ptw_pkg.
`default_nettype none

module ptw_store #(
	parameter int FRAMES = 64,
	localparam int FW = $clog2(FRAMES),
	localparam int AW = FW + ptw_pkg::IDX_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [63:0]        rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [63:0]   wr_data,
	output logic               busy
);
	import ptw_pkg::*;

	localparam int DEPTH = FRAMES * ENTRIES_PER_TABLE;

	logic [63:0]   mem [DEPTH];
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [63:0]   wd;

	// Sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Clearing pass owns the write port while it runs
	always_comb begin
		we = wr_en;
		wa = wr_addr;
		wd = wr_data;
		if (clr_busy_q) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = '0;
		end
	end

	// Write, and read with forwarding of a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			if (we && (wa == rd_addr)) begin
				rd_data <= wd;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

	assign busy = clr_busy_q;

endmodule

`default_nettype wire

// ===== rtl/ptw_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on ptw_pkg.
`default_nettype none

module ptw_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ptw_pkg::seq_flags_t flags,
	output ptw_pkg::act_t            act
);
	import ptw_pkg::*;

	upc_t   upc_q;
	upc_t   upc_d;
	uword_t uw;

	// Control program: latch, then alternate apply/eval per level, then emit
	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		case (pc)
			UPC_IDLE:  w = '{act: ACT_LATCH, seq: SEQ_WAIT_IN,  target: UPC_APPLY};
			UPC_APPLY: w = '{act: ACT_APPLY, seq: SEQ_BR_TERM,  target: UPC_EMIT};
			UPC_EVAL:  w = '{act: ACT_EVAL,  seq: SEQ_JUMP,     target: UPC_APPLY};
			UPC_EMIT:  w = '{act: ACT_EMIT,  seq: SEQ_WAIT_OUT, target: UPC_IDLE};
			default:   w = '{act: ACT_LATCH, seq: SEQ_WAIT_IN,  target: UPC_APPLY};
		endcase
		return w;
	endfunction

	// Hold the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	// Decode the control word and pick the next step
	always_comb begin
		uw    = ucode(upc_q);
		act   = uw.act;
		upc_d = upc_q;
		case (uw.seq)
			SEQ_WAIT_IN: begin
				if (flags.start) upc_d = uw.target;
			end
			SEQ_BR_TERM: begin
				upc_d = flags.term ? uw.target : upc_t'(upc_q + 2'd1);
			end
			SEQ_JUMP: begin
				upc_d = uw.target;
			end
			SEQ_WAIT_OUT: begin
				if (flags.out_free) upc_d = uw.target;
			end
			default: begin
				upc_d = UPC_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ptw_dpath.sv =====
// Walk datapath: request latch, entry evaluation, store writes, frame
// counter, base register and output register. Depends on ptw_pkg.
`default_nettype none

module ptw_dpath #(
	parameter int FRAMES = 64,
	localparam int FW = $clog2(FRAMES),
	localparam int AW = FW + ptw_pkg::IDX_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ptw_pkg::act_t        act,
	output ptw_pkg::seq_flags_t       flags,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ptw_pkg::req_t        in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ptw_pkg::rsp_t             out_data,
	input  wire logic                 cfg_we,
	input  wire logic [51:0]          cfg_wdata,
	input  wire logic                 mem_busy,
	output logic                      rd_en,
	output logic [AW-1:0]             rd_addr,
	input  wire logic [63:0]          rd_data,
	output logic                      wr_en,
	output logic [AW-1:0]             wr_addr,
	output logic [63:0]               wr_data
);
	import ptw_pkg::*;

	localparam int NW = $clog2(FRAMES + 1);

	// Request and walk registers
	op_t               op_q;
	logic [VA_W-1:0]   virt_q;
	logic [PA_W-1:0]   phys_q;
	logic [FLAG_W-1:0] flags_q;
	logic [FW-1:0]     frame_q;
	logic [FW-1:0]     child_q;
	logic [1:0]        level_q;
	dec_t              dec_q;
	logic [PA_W-1:0]   leaf_q;
	logic [NW-1:0]     nff_q;
	logic [PN_W-1:0]   base_pn_q;
	status_t           st_q;
	logic [PA_W-1:0]   pres_q;
	logic              fl_q;
	rsp_t              out_q;
	logic              out_valid_q;

	// Combinational
	logic            start;
	logic            out_free;
	logic            misaligned;
	logic            term;
	logic            present;
	logic            huge;
	logic [PN_W-1:0] e_pn;
	logic [PN_W-1:0] diff;
	logic            in_range;
	logic            frames_left;
	logic            is_map;
	logic [1:0]      tgt_level;
	dec_t            eval_dec;
	logic [PA_W-1:0] eval_leaf;
	logic [FW-1:0]   rd_frame;
	logic [1:0]      rd_level;
	logic [PN_W-1:0] link_pn;

	// 9-bit table index for a level
	function automatic logic [IDX_W-1:0] idx_of(logic [VA_W-1:0] va, logic [1:0] lvl);
		logic [IDX_W-1:0] r;
		case (lvl)
			2'd0:    r = va[47:39];
			2'd1:    r = va[38:30];
			2'd2:    r = va[29:21];
			default: r = va[20:12];
		endcase
		return r;
	endfunction

	// Handshake and sequencer conditions
	assign in_ready = (act == ACT_LATCH) && !mem_busy;
	assign start    = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign term     = (dec_q != DEC_GO) && (dec_q != DEC_DESCEND) && (dec_q != DEC_ALLOC);
	assign flags    = '{start: start, out_free: out_free, term: term};

	// Alignment check on the incoming request
	always_comb begin
		case (op_t'(in_data.operation))
			OP_MAP_4K: misaligned = |(in_data.virt_addr[11:0] | in_data.phys_addr[11:0]);
			OP_MAP_2M: misaligned = |(in_data.virt_addr[20:0] | in_data.phys_addr[20:0]);
			default:   misaligned = 1'b0;
		endcase
	end

	// Evaluate the entry read at the current level
	always_comb begin
		present     = rd_data[BIT_PRESENT];
		huge        = rd_data[BIT_HUGE];
		e_pn        = rd_data[51:12];
		diff        = e_pn - base_pn_q;
		in_range    = (e_pn >= base_pn_q) && (diff < PN_W'(FRAMES));
		frames_left = nff_q < NW'(FRAMES);
		is_map      = (op_q == OP_MAP_4K) || (op_q == OP_MAP_2M);
		tgt_level   = (op_q == OP_MAP_2M) ? 2'd2 : 2'd3;

		if (is_map && (level_q == tgt_level)) begin
			eval_dec = DEC_WLEAF;
		end else if ((op_q == OP_UNMAP_4K) && (level_q == 2'd3)) begin
			eval_dec = present ? DEC_UNMAP : DEC_NM;
		end else if ((op_q == OP_TRANSLATE) && (level_q == 2'd3)) begin
			eval_dec = present ? DEC_LEAF : DEC_NM;
		end else if (!present) begin
			if (is_map) eval_dec = frames_left ? DEC_ALLOC : DEC_NOFR;
			else        eval_dec = DEC_NM;
		end else if (huge) begin
			eval_dec = ((op_q == OP_TRANSLATE) && (level_q != 2'd0)) ? DEC_LEAF : DEC_BAD;
		end else if (!in_range) begin
			eval_dec = DEC_BAD;
		end else begin
			eval_dec = DEC_DESCEND;
		end

		case (level_q)
			2'd1:    eval_leaf = {rd_data[51:30], virt_q[29:0]};
			2'd2:    eval_leaf = {rd_data[51:21], virt_q[20:0]};
			2'd3:    eval_leaf = {rd_data[51:12], virt_q[11:0]};
			default: eval_leaf = '0;
		endcase
	end

	// Store accesses issued by the apply step
	always_comb begin
		link_pn  = base_pn_q + PN_W'(nff_q);
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = {frame_q, idx_of(virt_q, level_q)};
		wr_data  = '0;
		case (dec_q)
			DEC_DESCEND: rd_frame = child_q;
			DEC_ALLOC:   rd_frame = nff_q[FW-1:0];
			default:     rd_frame = frame_q;
		endcase
		rd_level = (dec_q == DEC_GO) ? level_q : level_q + 2'd1;
		rd_addr  = {rd_frame, idx_of(virt_q, rd_level)};
		if (act == ACT_APPLY) begin
			case (dec_q)
				DEC_GO, DEC_DESCEND: begin
					rd_en = 1'b1;
				end
				DEC_ALLOC: begin
					rd_en   = 1'b1;
					wr_en   = 1'b1;
					wr_data = {12'h000, link_pn, LINK_FLAGS};
				end
				DEC_WLEAF: begin
					wr_en = 1'b1;
					if (op_q == OP_MAP_2M) begin
						wr_data = {12'h000, phys_q[51:21], 9'h000,
							flags_q | LEAF_PRESENT | LEAF_HUGE};
					end else begin
						wr_data = {12'h000, phys_q[51:12], flags_q | LEAF_PRESENT};
					end
				end
				DEC_UNMAP: begin
					wr_en = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers: base, frame counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_pn_q   <= PN_W'(40'h100);
			nff_q       <= NW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_pn_q <= cfg_wdata[51:12];
			end
			if ((act == ACT_APPLY) && (dec_q == DEC_ALLOC)) begin
				nff_q <= nff_q + NW'(1);
			end
			if ((act == ACT_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk and result registers
	always_ff @(posedge clk) begin
		case (act)
			ACT_LATCH: begin
				if (start) begin
					op_q    <= op_t'(in_data.operation);
					virt_q  <= in_data.virt_addr;
					phys_q  <= in_data.phys_addr;
					flags_q <= in_data.page_flags;
					frame_q <= '0;
					level_q <= 2'd0;
					dec_q   <= misaligned ? DEC_MIS : DEC_GO;
				end
			end
			ACT_EVAL: begin
				dec_q   <= eval_dec;
				child_q <= diff[FW-1:0];
				leaf_q  <= eval_leaf;
			end
			ACT_APPLY: begin
				pres_q <= '0;
				fl_q   <= 1'b0;
				case (dec_q)
					DEC_DESCEND: begin
						frame_q <= child_q;
						level_q <= level_q + 2'd1;
					end
					DEC_ALLOC: begin
						frame_q <= nff_q[FW-1:0];
						level_q <= level_q + 2'd1;
					end
					DEC_LEAF: begin
						st_q   <= ST_OK;
						pres_q <= leaf_q;
					end
					DEC_WLEAF, DEC_UNMAP: begin
						st_q <= ST_OK;
						fl_q <= 1'b1;
					end
					DEC_NM:   st_q <= ST_NOT_MAPPED;
					DEC_BAD:  st_q <= ST_BAD_WALK;
					DEC_NOFR: st_q <= ST_NO_FRAMES;
					DEC_MIS:  st_q <= ST_MISALIGNED;
					default: begin
					end
				endcase
			end
			ACT_EMIT: begin
				if (out_free) begin
					out_q <= '{status: st_q, phys_result: pres_q, flush_valid: fl_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The last level always ends the walk
	a_last_level_term: assert property (@(posedge clk) disable iff (!arst_n)
		(act == ACT_EVAL) && (level_q == 2'd3) |=>
		(dec_q != DEC_GO) && (dec_q != DEC_DESCEND) && (dec_q != DEC_ALLOC))
		else $error("walk continued past the page table level");

	// Allocation only while frames remain
	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(act == ACT_APPLY) && (dec_q == DEC_ALLOC) |-> (nff_q < NW'(FRAMES)))
		else $error("table frame allocated beyond the store");

	// The frame counter never moves back
	a_nff_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (nff_q >= $past(nff_q)))
		else $error("free frame counter decreased");

	// A flush goes with success and no translated address
	a_flush_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.flush_valid |->
		(out_q.status == ST_OK) && (out_q.phys_result == '0))
		else $error("flush raised on a failed or translate transaction");

endmodule

`default_nettype wire
